FILE: design/pwlts_pkg.sv
// Shared types, constants and helpers for the piecewise-linear time scale.
// Used by the controller, the datapath and the top level; no dependencies of its own.
`timescale 1ns / 1ps
package pwlts_pkg;

  localparam int MAX_WORDS = 16;
  localparam int AW        = 4;   // table address bits
  localparam int FRAC_BITS = 16;

  localparam logic [4:0] MAX_WORDS_C = 5'(MAX_WORDS);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  // register indexes on the config port
  localparam logic REG_WORD_COUNT   = 1'b0;
  localparam logic REG_REPEAT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_CYCLE = 2'd1,
    KIND_LAST  = 2'd2,
    KIND_FIRST = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_LOAD, OP_PAUSE1, OP_PAUSE2,
    OP_EV_CYCLE, OP_EV_LAST, OP_EV_FIRST,
    OP_STEP, OP_KEEP_DUR, OP_CAP_S, OP_CAP_E,
    OP_MUL, OP_DIV, OP_OUT_VAL, OP_OUT_LAST
  } op_t;

  typedef enum logic [1:0] {
    RD_DUR, RD_START, RD_END, RD_LASTW
  } rsel_t;

  typedef struct packed {
    op_t   op;
    rsel_t rsel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic seg_end;
    logic t_neg;
    logic t_lt_dur;
    logic cl_zero;
    logic div_last;
  } sts_t;

  typedef struct packed {
    logic        wc_we;
    logic        rc_we;
    logic [31:0] wdata;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

endpackage

FILE: design/pwlts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pwlts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pwlts_datapath.sv
// Datapath: table RAM, config registers, time/segment state, multiplier,
// bit-serial divider and the output word register. Uses pwlts_pkg, pwlts_ram.
`timescale 1ns / 1ps
module pwlts_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pwlts_pkg::cmd_t     cmd,
  input  pwlts_pkg::cfg_t     cfg,
  input  logic signed [31:0]  elapsed,
  input  logic                paused_in,
  input  logic [3:0]          word_index,
  input  logic signed [31:0]  word_value,
  output pwlts_pkg::sts_t     sts,
  output logic                out_valid,
  input  logic                out_ready,
  output pwlts_pkg::kind_t    out_kind,
  output logic signed [16:0]  out_cycle,
  output logic signed [31:0]  out_value,
  output logic signed [31:0]  out_inc,
  output logic                out_last,
  output logic [4:0]          word_count,
  output logic signed [16:0]  repeat_count
);

  logic signed [16:0] cycles_left;
  logic [4:0]         seg;
  logic signed [31:0] last_time, pause_total, t;
  logic               paused;
  logic signed [35:0] inc;
  logic [30:0]        dur;
  logic signed [31:0] s_val, e_val;
  logic               diff_neg;
  logic [31:0]        abs_diff;
  logic [30:0]        rem;
  logic [31:0]        low, quo;
  logic [4:0]         cnt;

  logic [4:0]            size;
  logic [pwlts_pkg::AW-1:0] raddr;
  logic [31:0]           rdata;
  logic [30:0]           dur_c;
  logic signed [32:0]    d33;
  logic signed [32:0]    dpos;
  logic signed [31:0]    pt_new, t_sub;
  logic [31:0]           rem2;
  logic                  ge;
  logic [31:0]           rdiff;
  logic [62:0]           prod;
  logic signed [32:0]    diff33;
  logic signed [33:0]    qs, v34, lo34, hi34, vcl;
  logic signed [35:0]    inc_fin;
  logic                  emit;
  logic                  out_free;

  pwlts_ram #(.WIDTH(32), .DEPTH(pwlts_pkg::MAX_WORDS)) u_table (
    .clk   (clk),
    .we    (cmd.op == pwlts_pkg::OP_WRITE),
    .waddr (word_index),
    .wdata (word_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    size = (word_count > pwlts_pkg::MAX_WORDS_C) ? pwlts_pkg::MAX_WORDS_C : word_count;
    case (cmd.rsel)
      pwlts_pkg::RD_DUR:   raddr = 4'(seg + 5'd1);
      pwlts_pkg::RD_START: raddr = seg[3:0];
      pwlts_pkg::RD_END:   raddr = 4'(seg + 5'd2);
      default:             raddr = 4'(size - 5'd1);
    endcase

    // |duration|, most negative word saturates
    if (rdata == 32'h8000_0000) dur_c = 31'h7FFF_FFFF;
    else if (rdata[31])         dur_c = 31'(-rdata);
    else                        dur_c = rdata[30:0];

    d33    = {t[31], t} - {last_time[31], last_time};
    dpos   = d33[32] ? 33'sd0 : d33;
    pt_new = pwlts_pkg::sat32({{4{pause_total[31]}}, pause_total} + {{3{dpos[32]}}, dpos});
    t_sub  = pwlts_pkg::sat32({{4{t[31]}}, t} - {{4{pause_total[31]}}, pause_total});

    rem2  = {rem, low[31]};
    ge    = rem2 >= {1'b0, dur};
    rdiff = rem2 - {1'b0, dur};
    prod  = 63'(t[30:0]) * 63'(abs_diff);

    // end word is still on the RAM output while it is captured
    diff33 = {rdata[31], rdata} - {s_val[31], s_val};
    qs     = diff_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    v34    = {{2{s_val[31]}}, s_val} + qs;
    lo34   = (s_val <= e_val) ? {{2{s_val[31]}}, s_val} : {{2{e_val[31]}}, e_val};
    hi34   = (s_val <= e_val) ? {{2{e_val[31]}}, e_val} : {{2{s_val[31]}}, s_val};
    if (v34 < lo34)      vcl = lo34;
    else if (v34 > hi34) vcl = hi34;
    else                 vcl = v34;
    inc_fin = inc + {{4{t[31]}}, t};

    out_free = !out_valid || out_ready;
    sts.out_free = out_free;
    sts.seg_end  = ({1'b0, seg} + 6'd2) >= {1'b0, size};
    sts.t_neg    = t[31];
    sts.t_lt_dur = t < $signed({1'b0, dur_c});
    sts.cl_zero  = (cycles_left == 17'sd0);
    sts.div_last = (cnt == 5'd31);

    emit = (cmd.op == pwlts_pkg::OP_EV_CYCLE) || (cmd.op == pwlts_pkg::OP_EV_LAST) ||
           (cmd.op == pwlts_pkg::OP_EV_FIRST) || (cmd.op == pwlts_pkg::OP_OUT_VAL) ||
           (cmd.op == pwlts_pkg::OP_OUT_LAST);
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count   <= '0;
      repeat_count <= '0;
      cycles_left  <= '0;
      seg          <= '0;
      last_time    <= '0;
      pause_total  <= '0;
      out_valid    <= 1'b0;
      cnt          <= '0;
    end else begin
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg.wc_we) begin
        word_count <= cfg.wdata[4:0];
        seg        <= '0;
      end
      if (cfg.rc_we) begin
        repeat_count <= cfg.wdata[16:0];
        cycles_left  <= cfg.wdata[16:0];
      end
      case (cmd.op)
        pwlts_pkg::OP_PAUSE1: begin
          if (paused) pause_total <= pt_new;
          else        last_time   <= t;
        end
        pwlts_pkg::OP_EV_CYCLE: begin
          seg <= '0;
          if (!cycles_left[16]) cycles_left <= cycles_left - 17'sd1;
        end
        pwlts_pkg::OP_STEP: seg <= seg + 5'd2;
        pwlts_pkg::OP_MUL:  cnt <= '0;
        pwlts_pkg::OP_DIV:  cnt <= cnt + 5'd1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      pwlts_pkg::OP_LOAD: begin
        t      <= elapsed;
        paused <= paused_in;
        inc    <= '0;
      end
      pwlts_pkg::OP_PAUSE2: if (paused) t <= t_sub;
      pwlts_pkg::OP_STEP: begin
        t   <= t - $signed({1'b0, dur_c});
        inc <= inc + 36'(dur_c);
      end
      pwlts_pkg::OP_KEEP_DUR: dur <= dur_c;
      pwlts_pkg::OP_CAP_S:    s_val <= rdata;
      pwlts_pkg::OP_CAP_E: begin
        e_val    <= rdata;
        diff_neg <= diff33[32];
        abs_diff <= diff33[32] ? 32'(-diff33) : diff33[31:0];
      end
      pwlts_pkg::OP_MUL: begin
        rem <= prod[62:32];
        low <= prod[31:0];
      end
      pwlts_pkg::OP_DIV: begin
        rem <= ge ? rdiff[30:0] : rem2[30:0];
        low <= {low[30:0], 1'b0};
        quo <= {quo[30:0], ge};
      end
      default: ;
    endcase
    // output word register
    case (cmd.op)
      pwlts_pkg::OP_EV_CYCLE: begin
        out_kind  <= pwlts_pkg::KIND_CYCLE;
        out_cycle <= cycles_left[16] ? -17'sd1 : repeat_count - cycles_left;
        out_value <= '0;
        out_inc   <= '0;
        out_last  <= 1'b0;
      end
      pwlts_pkg::OP_EV_LAST, pwlts_pkg::OP_EV_FIRST: begin
        out_kind  <= (cmd.op == pwlts_pkg::OP_EV_LAST) ? pwlts_pkg::KIND_LAST
                                                       : pwlts_pkg::KIND_FIRST;
        out_cycle <= '0;
        out_value <= '0;
        out_inc   <= '0;
        out_last  <= 1'b0;
      end
      pwlts_pkg::OP_OUT_VAL: begin
        out_kind  <= pwlts_pkg::KIND_VALUE;
        out_cycle <= '0;
        out_value <= vcl[31:0];
        out_inc   <= pwlts_pkg::sat32(inc);
        out_last  <= 1'b1;
      end
      pwlts_pkg::OP_OUT_LAST: begin
        out_kind  <= pwlts_pkg::KIND_VALUE;
        out_cycle <= '0;
        out_value <= (size != 5'd0) ? rdata : pwlts_pkg::ONE_Q;
        out_inc   <= pwlts_pkg::sat32(inc_fin);
        out_last  <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/pwlts_ctrl.sv
// Controller: sequences pause bookkeeping, end-of-table events, the segment
// walk and the interpolation divide. Uses pwlts_pkg.
`timescale 1ns / 1ps
module pwlts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_func,
  output logic            in_ready,
  input  pwlts_pkg::sts_t sts,
  output pwlts_pkg::cmd_t cmd
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_PAUSE_A   = 16'h0002,
    S_PAUSE_B   = 16'h0004,
    S_CHECK     = 16'h0008,
    S_EOT_CYC   = 16'h0010,
    S_EOT_LAST  = 16'h0020,
    S_EOT_FIRST = 16'h0040,
    S_WALK      = 16'h0080,
    S_DUR       = 16'h0100,
    S_RD_S      = 16'h0200,
    S_RD_E      = 16'h0400,
    S_MUL       = 16'h0800,
    S_DIV       = 16'h1000,
    S_VAL_OUT   = 16'h2000,
    S_RD_LAST   = 16'h4000,
    S_LAST_OUT  = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   post, post_next;    // end-of-table pass closes the item
  state_t ret;

  assign in_ready = (state == S_IDLE);
  assign ret      = post ? S_RD_LAST : S_WALK;

  always_comb begin
    state_next = state;
    post_next  = post;
    cmd.op     = pwlts_pkg::OP_NONE;
    cmd.rsel   = pwlts_pkg::RD_DUR;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            cmd.op = pwlts_pkg::OP_WRITE;
          end else begin
            cmd.op     = pwlts_pkg::OP_LOAD;
            state_next = S_PAUSE_A;
          end
        end
      end
      S_PAUSE_A: begin
        cmd.op     = pwlts_pkg::OP_PAUSE1;
        state_next = S_PAUSE_B;
      end
      S_PAUSE_B: begin
        cmd.op     = pwlts_pkg::OP_PAUSE2;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        post_next  = 1'b0;
        state_next = sts.seg_end ? S_EOT_CYC : S_WALK;
      end
      S_EOT_CYC: begin
        if (sts.cl_zero) begin
          state_next = S_EOT_LAST;
        end else if (sts.out_free) begin
          cmd.op     = pwlts_pkg::OP_EV_CYCLE;
          state_next = S_EOT_LAST;
        end
      end
      S_EOT_LAST: begin
        if (!sts.cl_zero) begin
          state_next = ret;
        end else if (sts.out_free) begin
          cmd.op     = pwlts_pkg::OP_EV_LAST;
          state_next = S_EOT_FIRST;
        end
      end
      S_EOT_FIRST: begin
        if (sts.out_free) begin
          cmd.op     = pwlts_pkg::OP_EV_FIRST;
          state_next = ret;
        end
      end
      S_WALK: begin
        if (sts.t_neg || sts.seg_end) begin
          post_next  = 1'b1;
          state_next = S_EOT_CYC;
        end else begin
          state_next = S_DUR;
        end
      end
      S_DUR: begin
        if (sts.t_lt_dur) begin
          cmd.op     = pwlts_pkg::OP_KEEP_DUR;
          cmd.rsel   = pwlts_pkg::RD_START;
          state_next = S_RD_S;
        end else begin
          cmd.op     = pwlts_pkg::OP_STEP;
          state_next = S_WALK;
        end
      end
      S_RD_S: begin
        cmd.op     = pwlts_pkg::OP_CAP_S;
        cmd.rsel   = pwlts_pkg::RD_END;
        state_next = S_RD_E;
      end
      S_RD_E: begin
        cmd.op     = pwlts_pkg::OP_CAP_E;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = pwlts_pkg::OP_MUL;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = pwlts_pkg::OP_DIV;
        if (sts.div_last) state_next = S_VAL_OUT;
      end
      S_VAL_OUT: begin
        if (sts.out_free) begin
          cmd.op     = pwlts_pkg::OP_OUT_VAL;
          state_next = S_IDLE;
        end
      end
      S_RD_LAST: begin
        cmd.rsel   = pwlts_pkg::RD_LASTW;
        state_next = S_LAST_OUT;
      end
      S_LAST_OUT: begin
        cmd.rsel = pwlts_pkg::RD_LASTW;
        if (sts.out_free) begin
          cmd.op     = pwlts_pkg::OP_OUT_LAST;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      post  <= 1'b0;
    end else begin
      state <= state_next;
      post  <= post_next;
    end
  end

endmodule

FILE: design/piecewise_linear_time_scale.sv
// Top level of the piecewise-linear time scale: stream ports, APB register
// port, controller and datapath. Uses pwlts_pkg, pwlts_ctrl, pwlts_datapath.
`timescale 1ns / 1ps
// One word at a time. A table write completes in the idle state. A sample
// passes through acceptance and pause bookkeeping, a walk test and a duration
// read per skipped segment (one table RAM read each), then the tests on the
// hit segment, the operand reads and the multiply, the 1-bit-per-cycle divider
// and the value issue. Each pass over the table end goes through the cycle,
// last and first event states, and a sample that runs off the end finishes
// with the walk test, the last-word read and the issue. Each result word
// leaves through an output register and may be stalled freely; a stall
// holds the controller until the word is taken.
module piecewise_linear_time_scale (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // elapsed[31:0], paused[32], word_index[36:33],
                                 // word_value[68:37], zero pad
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // cycle_number[16:0], scaled_value[48:17],
                                 // accum_increment[80:49], zero pad
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast,   // last_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pwlts_pkg::cmd_t  cmd;
  pwlts_pkg::sts_t  sts;
  pwlts_pkg::cfg_t  cfg;
  pwlts_pkg::kind_t out_kind;
  logic signed [16:0] out_cycle;
  logic signed [31:0] out_value, out_inc;
  logic [4:0]         word_count;
  logic signed [16:0] repeat_count;
  logic               wr;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign cfg.wc_we = wr && (paddr[2] == pwlts_pkg::REG_WORD_COUNT);
  assign cfg.rc_we = wr && (paddr[2] == pwlts_pkg::REG_REPEAT_COUNT);
  assign cfg.wdata = pwdata;
  assign prdata    = (paddr[2] == pwlts_pkg::REG_WORD_COUNT) ? {27'd0, word_count}
                                                             : {{15{repeat_count[16]}}, repeat_count};

  pwlts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pwlts_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .elapsed      (s_tdata[31:0]),
    .paused_in    (s_tdata[32]),
    .word_index   (s_tdata[36:33]),
    .word_value   (s_tdata[68:37]),
    .sts          (sts),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_kind     (out_kind),
    .out_cycle    (out_cycle),
    .out_value    (out_value),
    .out_inc      (out_inc),
    .out_last     (m_tlast),
    .word_count   (word_count),
    .repeat_count (repeat_count)
  );

  assign m_tuser = out_kind;
  assign m_tdata = {7'd0, out_inc, out_value, out_cycle};

  // the closing word of a sample is always the scaled value
  a_last_is_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == pwlts_pkg::KIND_VALUE)
    else $error("final word is not a scaled value");

  // only cycle events carry a cycle number
  a_cycle_field: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != pwlts_pkg::KIND_CYCLE |-> m_tdata[16:0] == 17'd0)
    else $error("cycle number on a non-cycle word");

  // an event word leaves while its sample is still being worked on
  a_event_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("event word with controller idle");

endmodule
